// ===== hw/rtl/fpa_pkg.sv =====
// Shared types, operation codes and constants of the fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;

    // Number of fraction bits in a raw value.
    localparam int FRAC_BITS = 8;

    // Command queue between front and back.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = 2;

    // Result queue at the output of the back part.
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = 2;

    // Quotient bits produced by the divider, one per cycle.
    localparam int DIV_STEPS  = 64;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_LT       = 4'd4,
        OP_GT       = 4'd5,
        OP_LE       = 4'd6,
        OP_GE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } t_op;

    // How the back part has to treat a command.
    typedef enum logic [1:0] {
        CL_PLAIN = 2'd0,
        CL_DIV   = 2'd1,
        CL_DZ    = 2'd2
    } t_class;

    typedef struct packed {
        t_op                op;
        t_class             cls;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] value;
        logic               cmp;
        logic               dz;
    } t_res;

    // Status of the command queue as seen by its neighbours.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== hw/rtl/fpa_front.sv =====
// Front part: input register that accepts beats and classifies each command.
`timescale 1ns / 1ps
module fpa_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         i_operation,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    input  fpa_pkg::t_qstat    i_qstat,
    output logic               o_wr,
    output fpa_pkg::t_cmd      o_cmd
);
    import fpa_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_cmd   r_cmd;
    t_cmd   n_cmd;
    logic   accept;

    // The register moves on whenever the queue takes its beat.
    assign o_wr   = r_valid && !i_qstat.full;
    assign full   = r_valid && i_qstat.full;
    assign accept = push && !full;
    assign o_cmd  = r_cmd;

    // Classification: a divide with a zero divisor needs no divider.
    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (o_wr) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid   = 1'b1;
            n_cmd.op  = t_op'(i_operation);
            n_cmd.a   = i_operand_a;
            n_cmd.b   = i_operand_b;
            n_cmd.cls = CL_PLAIN;
            if (t_op'(i_operation) == OP_DIV) begin
                n_cmd.cls = (i_operand_b == 32'sd0) ? CL_DZ : CL_DIV;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

// ===== hw/rtl/fpa_cmdq.sv =====
// Short command queue that decouples the front part from the back part.
`timescale 1ns / 1ps
module fpa_cmdq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  fpa_pkg::t_cmd   i_cmd,
    input  logic            i_rd,
    output fpa_pkg::t_cmd   o_cmd,
    output fpa_pkg::t_qstat o_qstat
);
    import fpa_pkg::*;

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wp;
    logic [CMDQ_AW-1:0] r_rp;
    logic [CMDQ_AW:0]   r_cnt;
    logic               wr_ok;
    logic               rd_ok;

    assign o_qstat.full  = (r_cnt == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign wr_ok = i_wr && !o_qstat.full;
    assign rd_ok = i_rd && !o_qstat.empty;
    assign o_cmd = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            if (wr_ok && !rd_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_ok && !wr_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/fpa_back.sv =====
// Back part: execute stage, serial divider and result queue.
`timescale 1ns / 1ps
module fpa_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fpa_pkg::t_cmd      i_cmd,
    input  fpa_pkg::t_qstat    i_qstat,
    output logic               o_rd,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_value,
    output logic               o_compare_true,
    output logic               o_divide_by_zero
);
    import fpa_pkg::*;

    // Execute stage register.
    logic               r_s1v;
    logic               n_s1v;
    logic               r_s1_mul;
    logic               n_s1_mul;
    logic signed [63:0] r_s1_prod;
    logic signed [63:0] n_s1_prod;
    t_res               r_s1_res;
    t_res               n_s1_res;

    // Divider state.
    logic               r_busy;
    logic               n_busy;
    logic [6:0]         r_dcnt;
    logic [6:0]         n_dcnt;
    logic [63:0]        r_num;
    logic [63:0]        n_num;
    logic [32:0]        r_rem;
    logic [32:0]        n_rem;
    logic [31:0]        r_den;
    logic [31:0]        n_den;
    logic               r_neg;
    logic               n_neg;

    // Result queue.
    t_res               r_oq [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] r_owp;
    logic [OUTQ_AW-1:0] r_orp;
    logic [OUTQ_AW:0]   r_ocnt;

    logic               space;
    logic               div_done;
    logic               oq_pop;
    logic [32:0]        rem_sh;
    logic [33:0]        diff;
    logic signed [63:0] num_s;
    logic [63:0]        num_mag;
    logic [63:0]        quo;
    t_res               s2_res;
    logic signed [63:0] prod_sh;

    // One beat may be in the execute stage, so reserve a slot for it.
    assign space    = ({1'b0, r_ocnt} + {{OUTQ_AW+1{1'b0}}, r_s1v})
                      < (OUTQ_AW+2)'(OUTQ_DEPTH);
    assign div_done = r_busy && (r_dcnt == 7'(DIV_STEPS));
    assign o_rd     = !i_qstat.empty && !r_busy && space;

    // Divider datapath: one restoring step per cycle.
    assign rem_sh  = {r_rem[31:0], r_num[63]};
    assign diff    = {1'b0, rem_sh} - {2'b00, r_den};
    assign num_s   = 64'(i_cmd.a) <<< FRAC_BITS;
    assign num_mag = num_s[63] ? 64'(-num_s) : 64'(num_s);
    assign quo     = r_neg ? (~r_num + 64'd1) : r_num;

    // Issue, execute and divider control.
    always_comb begin
        n_s1v     = 1'b0;
        n_s1_mul  = 1'b0;
        n_s1_prod = r_s1_prod;
        n_s1_res  = '0;
        n_busy    = r_busy;
        n_dcnt    = r_dcnt;
        n_num     = r_num;
        n_rem     = r_rem;
        n_den     = r_den;
        n_neg     = r_neg;
        if (r_busy && !div_done) begin
            n_dcnt = r_dcnt + 7'd1;
            if (!diff[33]) begin
                n_rem = diff[32:0];
                n_num = {r_num[62:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_num = {r_num[62:0], 1'b0};
            end
        end else if (div_done && space) begin
            n_busy         = 1'b0;
            n_s1v          = 1'b1;
            n_s1_res.value = quo[31:0];
        end else if (o_rd) begin
            case (i_cmd.cls)
                CL_DIV: begin
                    n_busy = 1'b1;
                    n_dcnt = '0;
                    n_num  = num_mag;
                    n_rem  = '0;
                    n_den  = i_cmd.b[31] ? 32'(-i_cmd.b) : 32'(i_cmd.b);
                    n_neg  = i_cmd.a[31] ^ i_cmd.b[31];
                end
                CL_DZ: begin
                    n_s1v       = 1'b1;
                    n_s1_res.dz = 1'b1;
                end
                default: begin
                    n_s1v = 1'b1;
                    case (i_cmd.op)
                        OP_ADD:      n_s1_res.value = i_cmd.a + i_cmd.b;
                        OP_SUB:      n_s1_res.value = i_cmd.a - i_cmd.b;
                        OP_MUL: begin
                            n_s1_mul  = 1'b1;
                            n_s1_prod = 64'(i_cmd.a) * 64'(i_cmd.b);
                        end
                        OP_LT:       n_s1_res.cmp = (i_cmd.a < i_cmd.b);
                        OP_GT:       n_s1_res.cmp = (i_cmd.a > i_cmd.b);
                        OP_LE:       n_s1_res.cmp = (i_cmd.a <= i_cmd.b);
                        OP_GE:       n_s1_res.cmp = (i_cmd.a >= i_cmd.b);
                        OP_EQ:       n_s1_res.cmp = (i_cmd.a == i_cmd.b);
                        OP_NE:       n_s1_res.cmp = (i_cmd.a != i_cmd.b);
                        OP_MIN:      n_s1_res.value = (i_cmd.a > i_cmd.b) ? i_cmd.b : i_cmd.a;
                        OP_MAX:      n_s1_res.value = (i_cmd.a < i_cmd.b) ? i_cmd.b : i_cmd.a;
                        OP_INC:      n_s1_res.value = i_cmd.a + 32'sd1;
                        OP_DEC:      n_s1_res.value = i_cmd.a - 32'sd1;
                        OP_FROM_INT: n_s1_res.value = i_cmd.a <<< FRAC_BITS;
                        OP_TO_INT:   n_s1_res.value = i_cmd.a >>> FRAC_BITS;
                        default:     n_s1_res = '0;
                    endcase
                end
            endcase
        end
    end

    // Second half of the multiply: the scaling shift on the registered product.
    assign prod_sh = r_s1_prod >>> FRAC_BITS;
    always_comb begin
        s2_res = r_s1_res;
        if (r_s1_mul) begin
            s2_res.value = prod_sh[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v  <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            r_s1v  <= n_s1v;
            r_busy <= n_busy;
        end
        r_s1_mul  <= n_s1_mul;
        r_s1_prod <= n_s1_prod;
        r_s1_res  <= n_s1_res;
        r_dcnt    <= n_dcnt;
        r_num     <= n_num;
        r_rem     <= n_rem;
        r_den     <= n_den;
        r_neg     <= n_neg;
    end

    // Result queue: the oldest beat is shown while it is not empty.
    assign empty            = (r_ocnt == '0);
    assign oq_pop           = pop && !empty;
    assign o_value          = r_oq[r_orp].value;
    assign o_compare_true   = r_oq[r_orp].cmp;
    assign o_divide_by_zero = r_oq[r_orp].dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (r_s1v) begin
                r_owp <= r_owp + 1'b1;
            end
            if (oq_pop) begin
                r_orp <= r_orp + 1'b1;
            end
            if (r_s1v && !oq_pop) begin
                r_ocnt <= r_ocnt + 1'b1;
            end else if (oq_pop && !r_s1v) begin
                r_ocnt <= r_ocnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1v) begin
            r_oq[r_owp] <= s2_res;
        end
    end

endmodule

// ===== hw/rtl/fixed_point_alu.sv =====
// Top level of the fixed-point ALU: front part, command queue and back part.
//
//  Channel   Handshake        Payload
//  input     push / full      i_operation, i_operand_a, i_operand_b
//  result    empty / pop      o_value, o_compare_true, o_divide_by_zero
//
// Every operation but divide issues one beat per cycle while the result side keeps
// up; a result passes through the input register, command queue, execute stage
// and result queue.
// A divide is issued, runs a one-bit-per-cycle restoring divider, then hands
// the quotient on to the execute stage, and holds later commands behind it in
// the command queue.
// Reset is synchronous and active low and empties all queues.
// A stalled result side fills the result queue, then the command queue, then
// raises full.
`timescale 1ns / 1ps
module fixed_point_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         i_operation,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_value,
    output logic               o_compare_true,
    output logic               o_divide_by_zero
);
    import fpa_pkg::*;

    t_cmd   front_cmd;
    t_cmd   head_cmd;
    t_qstat qstat;
    logic   q_wr;
    logic   q_rd;

    fpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_operation (i_operation),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_qstat     (qstat),
        .o_wr        (q_wr),
        .o_cmd       (front_cmd)
    );

    fpa_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_cmd   (front_cmd),
        .i_rd    (q_rd),
        .o_cmd   (head_cmd),
        .o_qstat (qstat)
    );

    fpa_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (head_cmd),
        .i_qstat          (qstat),
        .o_rd             (q_rd),
        .empty            (empty),
        .pop              (pop),
        .o_value          (o_value),
        .o_compare_true   (o_compare_true),
        .o_divide_by_zero (o_divide_by_zero)
    );

`ifndef SYNTHESIS
    // A zero-divisor beat carries a zero value.
    a_dz_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_divide_by_zero) |-> (o_value == 32'sd0))
        else $error("divide-by-zero beat with non-zero value");

    // A beat with the compare flag set carries a zero value.
    a_cmp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_compare_true) |-> (o_value == 32'sd0))
        else $error("comparison beat with non-zero value");

    // The two flags never come together.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_compare_true && o_divide_by_zero))
        else $error("comparison and divide-by-zero flags both set");

    // Directly after reset there is neither a result nor back-pressure.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");
`endif

endmodule

// ===== tb/fixed_point_alu_checker.sv =====
// Result checker of the fixed-point ALU: predicts every result beat and compares it.
`timescale 1ns / 1ps
module fixed_point_alu_checker
    import fpa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [3:0]         i_operation,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    input  logic               empty,
    input  logic               pop,
    input  logic signed [31:0] o_value,
    input  logic               o_compare_true,
    input  logic               o_divide_by_zero,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results
);

    typedef struct {
        logic signed [31:0] value;
        logic               cmp;
        logic               dz;
    } t_alu_result;

    t_alu_result alu_results_due[$];

    // Work out the result of one operation on raw values.
    function automatic t_alu_result alu_compute(t_op op, logic signed [31:0] a,
                                                logic signed [31:0] b);
        t_alu_result        r;
        logic signed [63:0] wide;
        logic signed [63:0] num;
        r.value = '0;
        r.cmp   = 1'b0;
        r.dz    = 1'b0;
        case (op)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL: begin
                wide    = 64'(a) * 64'(b);
                r.value = 32'(wide >>> FRAC_BITS);
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    num     = 64'(a) <<< FRAC_BITS;
                    r.value = 32'(num / 64'(b));
                end
            end
            OP_LT:       r.cmp = a < b;
            OP_GT:       r.cmp = a > b;
            OP_LE:       r.cmp = a <= b;
            OP_GE:       r.cmp = a >= b;
            OP_EQ:       r.cmp = a == b;
            OP_NE:       r.cmp = a != b;
            OP_MIN:      r.value = (a > b) ? b : a;
            OP_MAX:      r.value = (a < b) ? b : a;
            OP_INC:      r.value = a + 32'sd1;
            OP_DEC:      r.value = a - 32'sd1;
            OP_FROM_INT: r.value = a <<< FRAC_BITS;
            default:     r.value = a >>> FRAC_BITS;
        endcase
        return r;
    endfunction

    assign o_pending = alu_results_due.size();

    // Predict on each accepted input beat and compare each accepted result beat.
    always @(posedge i_clk) begin
        t_alu_result want;
        if (!i_rst_n) begin
            o_errors  <= 0;
            o_results <= 0;
        end else begin
            if (push && !full) begin
                alu_results_due.push_back(alu_compute(t_op'(i_operation),
                                                      i_operand_a, i_operand_b));
            end
            if (pop && !empty) begin
                o_results <= o_results + 1;
                if (alu_results_due.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) begin
                        $display("ERROR: unexpected result beat value=%0d", o_value);
                    end
                end else begin
                    want = alu_results_due.pop_front();
                    if (want.value !== o_value || want.cmp !== o_compare_true ||
                        want.dz !== o_divide_by_zero) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10) begin
                            $display("ERROR: expected value=%0d cmp=%0b dz=%0b, got %0d %0b %0b",
                                     want.value, want.cmp, want.dz,
                                     o_value, o_compare_true, o_divide_by_zero);
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== tb/fixed_point_alu_tb.sv =====
// Testbench top of the fixed-point ALU: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module fixed_point_alu_tb;
    import fpa_pkg::*;

    localparam int RANDOM_BEATS = 550;
    localparam int STALL_LIMIT  = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [3:0]         i_operation = '0;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [31:0] o_value;
    logic               o_compare_true;
    logic               o_divide_by_zero;
    int                 errors;
    int                 pending;
    int                 results;
    int                 idle_cycles = 0;
    bit                 calm = 1'b0;
    bit                 timed_out = 1'b0;
    int                 beats_sent = 0;

    always #4 i_clk = ~i_clk;

    fixed_point_alu u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_operation(i_operation), .i_operand_a(i_operand_a),
        .i_operand_b(i_operand_b), .empty(empty), .pop(pop), .o_value(o_value),
        .o_compare_true(o_compare_true), .o_divide_by_zero(o_divide_by_zero)
    );

    fixed_point_alu_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_operation(i_operation), .i_operand_a(i_operand_a),
        .i_operand_b(i_operand_b), .empty(empty), .pop(pop), .o_value(o_value),
        .o_compare_true(o_compare_true), .o_divide_by_zero(o_divide_by_zero),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // Result side: pop at random, never stalling while calm is set.
    always @(posedge i_clk) begin
        pop <= calm || ($urandom_range(99) >= 14);
    end

    // Watchdog on cycles where neither channel moves a beat.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("FAIL");
            $finish;
        end
    end

    // Operand with a bias toward edge values and small fixed-point numbers.
    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return '0;
            3: return 32'($urandom_range(4)) - 32'sd2;
            4, 5: return 32'($urandom_range(65535)) - 32'sd32768;
            default: return $urandom;
        endcase
    endfunction

    // Send one input beat and hold it until accepted.
    task automatic send_beat(t_op op, logic signed [31:0] a, logic signed [31:0] b,
                             bit may_idle);
        while (may_idle && $urandom_range(99) < 14) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_operation <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        beats_sent++;
    endtask

    initial begin
        t_op op;
        bit  quiet;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every operation on extremes, zero divisor, equal operands.
        for (int k = 0; k < 16; k++) begin
            send_beat(t_op'(k), 32'sh7FFFFFFF, 32'sh80000000, 1'b1);
        end
        send_beat(OP_DIV, 32'sh00000300, 32'sh0, 1'b0);
        send_beat(OP_DIV, 32'sh80000000, 32'shFFFFFFFF, 1'b0);
        send_beat(OP_DIV, -32'sd700, 32'sd256, 1'b0);
        send_beat(OP_MIN, 32'sd5, 32'sd5, 1'b0);
        send_beat(OP_MAX, -32'sd5, -32'sd5, 1'b0);
        send_beat(OP_TO_INT, -32'sd1, 32'sd0, 1'b0);
        send_beat(OP_INC, 32'sh7FFFFFFF, 32'sd0, 1'b0);
        send_beat(OP_DEC, 32'sh80000000, 32'sd0, 1'b0);
        send_beat(OP_MUL, -32'sd384, 32'sd640, 1'b0);
        push <= 1'b0;
        @(posedge i_clk);

        // Hold off until every outstanding result has come back.
        while (pending != 0) @(posedge i_clk);

        // Random part, with a quiet stretch where neither side idles.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            quiet = (n >= 200 && n < 300);
            calm  = quiet;
            // Divides stall the block while the divider runs, so keep them rarer.
            do op = t_op'($urandom_range(15));
            while (op == OP_DIV && $urandom_range(3) != 0);
            send_beat(op, pick_operand(), pick_operand(), !quiet);
        end
        push <= 1'b0;
        calm = 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Sent %0d beats covering all sixteen operations, edge operands", beats_sent);
        $display("and zero divisors; %0d results checked, %0d mismatches.", results, errors);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_front.sv
hw/rtl/fpa_cmdq.sv
hw/rtl/fpa_back.sv
hw/rtl/fixed_point_alu.sv
tb/fixed_point_alu_checker.sv
tb/fixed_point_alu_tb.sv
